// File: rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the three-band tone equalizer
// Fixed field widths, configuration register codes, sequencer states,
// controller command/status structs and the round/saturate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_FRAC_BITS = 16;
  localparam int COEFF_BITS      = COEFF_FRAC_BITS + 5;
  localparam int NUM_SECTIONS    = 3;
  localparam int FWD_W           = 3 * COEFF_BITS;
  localparam int FB_W            = 2 * COEFF_BITS;
  localparam int TRIM_BITS       = 17;
  localparam int TRIM_FRAC_BITS  = 16;
  localparam int TRIM_TOL        = 6;
  localparam logic [TRIM_BITS-1:0] TRIM_UNITY = TRIM_BITS'(65536);
  localparam logic [TRIM_BITS-1:0] TRIM_LO    = TRIM_BITS'(65536 - TRIM_TOL);
  localparam logic [TRIM_BITS-1:0] TRIM_HI    = TRIM_BITS'(65536 + TRIM_TOL);

  // coefficient x sample product and five-term sum
  localparam int PROD_W = COEFF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = FWD_W;

  localparam int MAC_TERMS = 5;
  localparam int STEP_W    = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAC_TERMS);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_FWD  = 3'd0,
    REG_LOW_FB   = 3'd1,
    REG_PEAK_FWD = 3'd2,
    REG_PEAK_FB  = 3'd3,
    REG_HIGH_FWD = 3'd4,
    REG_HIGH_FB  = 3'd5,
    REG_TRIM     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEC_LOW  = 2'd0,
    SEC_MID  = 2'd1,
    SEC_HIGH = 2'd2
  } section_e;

  typedef enum logic [2:0] {
    TERM_B0 = 3'd0,
    TERM_B1 = 3'd1,
    TERM_B2 = 3'd2,
    TERM_A1 = 3'd3,
    TERM_A2 = 3'd4
  } term_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_CHECK    = 3'd1,
    ST_MAC      = 3'd2,
    ST_SEC_END  = 3'd3,
    ST_TRIM_MUL = 3'd4,
    ST_TRIM_END = 3'd5,
    ST_DONE     = 3'd6
  } state_e;

  typedef struct packed {
    logic [NUM_SECTIONS-1:0][FWD_W-1:0] fwd;
    logic [NUM_SECTIONS-1:0][FB_W-1:0]  fb;
    logic [TRIM_BITS-1:0]               trim;
  } coef_set_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    logic     trim_mul;
    term_e    term;
    acc_op_e  acc_op;
    section_e sec;
    logic     sec_end;
    logic     trim_end;
    logic     out_load;
  } tte_cmd_t;

  typedef struct packed {
    logic in_range;
    logic trim_skip;
    logic out_free;
  } tte_status_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_row_t;

  // round half up from frac fraction bits, then clamp to a sample
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] v,
    input int unsigned             frac
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] s;
    r = v + (ACC_W'(1) << (frac - 1));
    s = r >>> frac;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tte_if.sv
// ----------------------------------------------------------------------------
// tte_if: channel interfaces of the tone equalizer
// Sample input, equalized output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tte_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tte_pkg::SAMPLE_BITS-1:0]   sample_in;
  logic                                     channel;
  logic                                     block_end;

  modport source (output valid, sample_in, channel, block_end, input ready);
  modport sink   (input valid, sample_in, channel, block_end, output ready);
endinterface

interface tte_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tte_pkg::SAMPLE_BITS-1:0]   sample_out;
  logic                                     channel_out;
  logic                                     block_end_out;

  modport source (output valid, sample_out, channel_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, channel_out, block_end_out, output ready);
endinterface

interface tte_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tte_pkg::CFG_INDEX_W-1:0]    index;
  logic [tte_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tte_cfg_regs.sv
// ----------------------------------------------------------------------------
// tte_cfg_regs: configuration register bank
// Decodes register writes into section coefficients and output trim.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  tte_cfg_if.sink             cfg,
  output tte_pkg::coef_set_t  coefs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tte_pkg::NUM_SECTIONS; i++) begin
        coefs.fwd[i] <= tte_pkg::FWD_W'(tte_pkg::TRIM_UNITY);  // b0 = 1.0
        coefs.fb[i]  <= '0;
      end
      coefs.trim <= tte_pkg::TRIM_UNITY;
    end else if (cfg.valid) begin
      case (tte_pkg::cfg_reg_e'(cfg.index))
        tte_pkg::REG_LOW_FWD:  coefs.fwd[tte_pkg::SEC_LOW]  <= cfg.data;
        tte_pkg::REG_LOW_FB:   coefs.fb[tte_pkg::SEC_LOW]   <= cfg.data[tte_pkg::FB_W-1:0];
        tte_pkg::REG_PEAK_FWD: coefs.fwd[tte_pkg::SEC_MID]  <= cfg.data;
        tte_pkg::REG_PEAK_FB:  coefs.fb[tte_pkg::SEC_MID]   <= cfg.data[tte_pkg::FB_W-1:0];
        tte_pkg::REG_HIGH_FWD: coefs.fwd[tte_pkg::SEC_HIGH] <= cfg.data;
        tte_pkg::REG_HIGH_FB:  coefs.fb[tte_pkg::SEC_HIGH]  <= cfg.data[tte_pkg::FB_W-1:0];
        tte_pkg::REG_TRIM:     coefs.trim <= cfg.data[tte_pkg::TRIM_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tte_ctrl.sv
// ----------------------------------------------------------------------------
// tte_ctrl: sequencer of the tone equalizer
// Steps the shared multiplier through five terms per section, three
// sections, the optional trim product and the output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tte_pkg::tte_status_t status,
  output tte_pkg::tte_cmd_t         cmd
);

  tte_pkg::state_e              state;
  tte_pkg::state_e              state_next;
  tte_pkg::section_e            sec;
  tte_pkg::section_e            sec_next;
  logic [tte_pkg::STEP_W-1:0]   step;
  logic [tte_pkg::STEP_W-1:0]   step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tte_pkg::ST_IDLE;
      sec   <= tte_pkg::SEC_LOW;
      step  <= '0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    sec_next   = sec;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sec    = sec;
    case (state)
      tte_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tte_pkg::ST_CHECK;
        end
      end
      tte_pkg::ST_CHECK: begin
        sec_next   = tte_pkg::SEC_LOW;
        step_next  = '0;
        state_next = status.in_range ? tte_pkg::ST_MAC : tte_pkg::ST_DONE;
      end
      tte_pkg::ST_MAC: begin
        // multiply term k while accumulating term k-1
        if (step < tte_pkg::STEP_LAST) begin
          cmd.mul_en = 1'b1;
          cmd.term   = tte_pkg::term_e'(step);
        end
        if (step != '0) begin
          cmd.acc_op = (step == tte_pkg::STEP_W'(1)) ? tte_pkg::ACC_LOAD : tte_pkg::ACC_ADD;
        end
        if (step == tte_pkg::STEP_LAST) begin
          step_next  = '0;
          state_next = tte_pkg::ST_SEC_END;
        end else begin
          step_next = step + tte_pkg::STEP_W'(1);
        end
      end
      tte_pkg::ST_SEC_END: begin
        cmd.sec_end = 1'b1;
        if (sec == tte_pkg::SEC_HIGH) begin
          state_next = status.trim_skip ? tte_pkg::ST_DONE : tte_pkg::ST_TRIM_MUL;
        end else begin
          sec_next   = tte_pkg::section_e'(sec + 2'd1);
          state_next = tte_pkg::ST_MAC;
        end
      end
      tte_pkg::ST_TRIM_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.trim_mul = 1'b1;
        state_next   = tte_pkg::ST_TRIM_END;
      end
      tte_pkg::ST_TRIM_END: begin
        cmd.trim_end = 1'b1;
        state_next   = tte_pkg::ST_DONE;
      end
      tte_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tte_pkg::ST_IDLE;
      end
    endcase
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == tte_pkg::ST_MAC |-> step <= tte_pkg::STEP_LAST)
    else $error("MAC step counter past last term");

  a_trim_after_high: assert property (@(posedge clk) disable iff (rst)
    state == tte_pkg::ST_TRIM_MUL |->
      $past(state) == tte_pkg::ST_SEC_END && $past(sec) == tte_pkg::SEC_HIGH)
    else $error("trim product started before the high shelf finished");

endmodule

`default_nettype wire

// File: rtl/tte_datapath.sv
// ----------------------------------------------------------------------------
// tte_datapath: shared multiply-accumulate datapath
// Holds the working sample, per-channel section history, one registered
// multiplier, the accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_datapath #(
  parameter int CHANNELS = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tte_pkg::tte_cmd_t                    cmd,
  output tte_pkg::tte_status_t                      status,
  input  wire tte_pkg::coef_set_t                   coefs,
  input  wire logic signed [tte_pkg::SAMPLE_BITS-1:0] sample_in,
  input  wire logic                                 channel,
  input  wire logic                                 block_end,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [tte_pkg::SAMPLE_BITS-1:0]    sample_out,
  output logic                                      channel_out,
  output logic                                      block_end_out
);

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [tte_pkg::SAMPLE_BITS-1:0] x;
  logic                                   ch;
  logic                                   be;
  logic signed [tte_pkg::PROD_W-1:0]      prod;
  logic                                   prod_neg;
  logic signed [tte_pkg::ACC_W-1:0]       acc;
  logic signed [tte_pkg::ACC_W-1:0]       prod_ext;

  tte_pkg::hist_row_t bass_hist   [CHANNELS];
  tte_pkg::hist_row_t mid_hist    [CHANNELS];
  tte_pkg::hist_row_t treble_hist [CHANNELS];

  logic [CIW-1:0]                         ch_idx;
  logic                                   in_range;
  tte_pkg::hist_row_t                     row_cur;
  tte_pkg::hist_row_t                     row_next;
  logic [tte_pkg::FWD_W-1:0]              fwd_sel;
  logic [tte_pkg::FB_W-1:0]               fb_sel;
  logic signed [tte_pkg::COEFF_BITS-1:0]  mul_a;
  logic signed [tte_pkg::SAMPLE_BITS-1:0] mul_b;
  logic signed [tte_pkg::SAMPLE_BITS-1:0] y_sec;
  logic signed [tte_pkg::SAMPLE_BITS-1:0] y_trim;

  assign ch_idx   = CIW'(ch);
  assign in_range = (32'(ch) < 32'(CHANNELS));

  assign status.in_range  = in_range;
  assign status.trim_skip = (coefs.trim >= tte_pkg::TRIM_LO) &&
                            (coefs.trim <= tte_pkg::TRIM_HI);
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    case (cmd.sec)
      tte_pkg::SEC_LOW: begin
        row_cur = bass_hist[ch_idx];
        fwd_sel = coefs.fwd[tte_pkg::SEC_LOW];
        fb_sel  = coefs.fb[tte_pkg::SEC_LOW];
      end
      tte_pkg::SEC_MID: begin
        row_cur = mid_hist[ch_idx];
        fwd_sel = coefs.fwd[tte_pkg::SEC_MID];
        fb_sel  = coefs.fb[tte_pkg::SEC_MID];
      end
      default: begin
        row_cur = treble_hist[ch_idx];
        fwd_sel = coefs.fwd[tte_pkg::SEC_HIGH];
        fb_sel  = coefs.fb[tte_pkg::SEC_HIGH];
      end
    endcase
  end

  always_comb begin
    if (cmd.trim_mul) begin
      mul_a = {{(tte_pkg::COEFF_BITS - tte_pkg::TRIM_BITS){1'b0}}, coefs.trim};
      mul_b = x;
    end else begin
      case (cmd.term)
        tte_pkg::TERM_B0: begin
          mul_a = fwd_sel[0 +: tte_pkg::COEFF_BITS];
          mul_b = x;
        end
        tte_pkg::TERM_B1: begin
          mul_a = fwd_sel[tte_pkg::COEFF_BITS +: tte_pkg::COEFF_BITS];
          mul_b = row_cur.x1;
        end
        tte_pkg::TERM_B2: begin
          mul_a = fwd_sel[2 * tte_pkg::COEFF_BITS +: tte_pkg::COEFF_BITS];
          mul_b = row_cur.x2;
        end
        tte_pkg::TERM_A1: begin
          mul_a = fb_sel[0 +: tte_pkg::COEFF_BITS];
          mul_b = row_cur.y1;
        end
        tte_pkg::TERM_A2: begin
          mul_a = fb_sel[tte_pkg::COEFF_BITS +: tte_pkg::COEFF_BITS];
          mul_b = row_cur.y2;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod_ext = tte_pkg::ACC_W'(prod);
  assign y_sec    = tte_pkg::round_sat(acc, tte_pkg::COEFF_FRAC_BITS);
  assign y_trim   = tte_pkg::round_sat(prod_ext, tte_pkg::TRIM_FRAC_BITS);

  always_comb begin
    row_next.x1 = x;
    row_next.x2 = row_cur.x1;
    row_next.y1 = y_sec;
    row_next.y2 = row_cur.y1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= sample_in;
      ch <= channel;
      be <= block_end;
    end else if (cmd.sec_end) begin
      x <= y_sec;
    end else if (cmd.trim_end) begin
      x <= y_trim;
    end
    if (cmd.mul_en) begin
      prod     <= tte_pkg::PROD_W'(mul_a) * tte_pkg::PROD_W'(mul_b);
      prod_neg <= !cmd.trim_mul &&
                  (cmd.term == tte_pkg::TERM_A1 || cmd.term == tte_pkg::TERM_A2);
    end
    case (cmd.acc_op)
      tte_pkg::ACC_LOAD: acc <= prod_neg ? -prod_ext : prod_ext;
      tte_pkg::ACC_ADD:  acc <= prod_neg ? acc - prod_ext : acc + prod_ext;
      default: ;
    endcase
    if (cmd.out_load) begin
      sample_out    <= x;
      channel_out   <= ch;
      block_end_out <= be;
    end
  end

  // history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        bass_hist[i]   <= '0;
        mid_hist[i]    <= '0;
        treble_hist[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.sec_end) begin
        case (cmd.sec)
          tte_pkg::SEC_LOW: bass_hist[ch_idx]   <= row_next;
          tte_pkg::SEC_MID: mid_hist[ch_idx]    <= row_next;
          default:          treble_hist[ch_idx] <= row_next;
        endcase
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while holding an item");

  a_hist_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sec_end |-> in_range)
    else $error("history written for a channel out of range");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_op != tte_pkg::ACC_HOLD |-> $past(cmd.mul_en))
    else $error("accumulate without a product from the previous cycle");

endmodule

`default_nettype wire

// File: rtl/three_band_tone_equalizer.sv
// ----------------------------------------------------------------------------
// three_band_tone_equalizer: low shelf / peak / high shelf biquad cascade
// Each item is one signed sample tagged with a channel and a block-end flag.
// in_ch takes items (valid/ready); out_ch returns one result item per input
// item in order, with the channel and block-end flag copied. cfg writes the
// six coefficient registers and the output trim; ready is always high and a
// write is applied directly, also to an item already in flight.
// One item is in flight at a time. A single registered multiplier steps
// through five products per section for three sections, then the trim
// product, skipped when the trim is within 6 LSB of unity (bypassed); an
// item with a channel number that has no history passes through unfiltered.
// A new item is taken only once the last is in the output register.
// The output register lets the next item be accepted while a result waits;
// if out_ch stalls, the finished item holds in the datapath until the output
// register is taken. Reset (synchronous) clears all filter history, sets each
// b0 to 1.0 and the other coefficients to 0, and trim to unity.
// ----------------------------------------------------------------------------
`default_nettype none

module three_band_tone_equalizer #(
  parameter int CHANNELS = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tte_in_if.sink     in_ch,
  tte_out_if.source  out_ch,
  tte_cfg_if.sink    cfg
);

  tte_pkg::coef_set_t   coefs;
  tte_pkg::tte_cmd_t    cmd;
  tte_pkg::tte_status_t status;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  tte_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .coefs (coefs)
  );

  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tte_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .coefs         (coefs),
    .sample_in     (in_ch.sample_in),
    .channel       (in_ch.channel),
    .block_end     (in_ch.block_end),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .sample_out    (out_ch.sample_out),
    .channel_out   (out_ch.channel_out),
    .block_end_out (out_ch.block_end_out)
  );

endmodule

`default_nettype wire
